>>> src/piecewise_linear_calibration_top_assert.svh
// Assertion helpers for the calibration RTL.
`ifndef PIECEWISE_LINEAR_CALIBRATION_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_TOP_ASSERT_SVH

// Same-cycle implication.
`define PWLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pwlc_pkg.sv
package pwlc_pkg;

    localparam int NUM_POINTS  = 6;
    localparam int TABLE_WORDS = 2 * NUM_POINTS;
    localparam int VAL_W       = 32;
    // quotient bits kept by the divider; anything larger saturates anyway
    localparam int DIV_STEPS   = 33;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [3:0]       table_select;
        logic [2:0]       point_index;
        logic             is_standard;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic             status;
        logic             bypassed;
    } t_out_item;

    // per-item flags that ride alongside the divider
    typedef struct packed {
        logic             wr;
        logic             pass;
        logic             status;
        logic             byp;
        logic             neg;
        logic             ovf;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] y0;
    } t_side;

endpackage

>>> src/pwlc_bank.sv
module pwlc_bank #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [pwlc_pkg::VAL_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [pwlc_pkg::VAL_W-1:0]    o_rdata
);

    logic [pwlc_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [pwlc_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pwlc_div.sv
module pwlc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2*pwlc_pkg::VAL_W-1:0] i_num,
    input  logic [pwlc_pkg::VAL_W-1:0] i_den,
    input  pwlc_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [pwlc_pkg::DIV_STEPS-1:0] o_quo,
    output logic [pwlc_pkg::VAL_W-1:0] o_rem,
    output logic [pwlc_pkg::VAL_W-1:0] o_den,
    output pwlc_pkg::t_side            o_side
);

    localparam int N = pwlc_pkg::DIV_STEPS;
    localparam int W = pwlc_pkg::VAL_W;

    logic                r_v    [N+1];
    logic [W-1:0]        r_rem  [N+1];
    logic [N-1:0]        r_qd   [N+1];  // low dividend bits in, quotient bits out
    logic [W-1:0]        r_den  [N+1];
    pwlc_pkg::t_side     r_side [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, i_num[2*W-1:N]};
            r_qd[0]   <= i_num[N-1:0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W:0] t;
        logic       take;

        assign t    = {r_rem[k], r_qd[k][N-1]};
        assign take = t >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= take ? W'(t - {1'b0, r_den[k]}) : t[W-1:0];
                r_qd[k+1]   <= {r_qd[k][N-2:0], take};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quo   = r_qd[N];
    assign o_rem   = r_rem[N];
    assign o_den   = r_den[N];
    assign o_side  = r_side[N];

endmodule

>>> src/piecewise_linear_calibration_top.sv
// Piecewise-linear calibration against six-point tables.
// Input channel (i_in_valid / o_in_stall / i_in_item): a write item stores one
// measured or standard point of a table; a convert item maps a sample through
// the table it selects. Every item yields exactly one result on the output
// channel (o_out_valid / i_out_stall / o_out_item); writes return all zeros.
// Throughput: one item per cycle while the receiver does not stall. Path from
// acceptance to the result register: table read, segment pick, differences,
// multiply, 33-step restoring divider, rounding, final select. The divider
// chain of one compare-subtract per stage sets the depth.
// A write is visible to a convert accepted in the very next cycle.
// Reset: a clearing pass zeroes the point tables, one table row per cycle;
// o_in_stall is high during it.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and o_in_stall rises in the same cycle; nothing is dropped or repeated.
`include "piecewise_linear_calibration_top_assert.svh"

module piecewise_linear_calibration_top #(
    parameter int NUM_TABLES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pwlc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pwlc_pkg::t_out_item  o_out_item
);

    localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int W  = pwlc_pkg::VAL_W;
    localparam int NP = pwlc_pkg::NUM_POINTS;
    localparam int TWORDS = pwlc_pkg::TABLE_WORDS;

    logic en;
    logic in_acc;

    // clearing pass
    logic          r_clr;
    logic [TW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            if (r_clr_idx == TW'(NUM_TABLES - 1)) begin
                r_clr <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    logic r_out_valid;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en || r_clr;
    assign in_acc     = i_in_valid && !o_in_stall;

    // stage 0: table access
    logic [5:0]    tsel_w;
    logic [TW-1:0] in_idx;
    logic          tbl_ok;
    logic [3:0]    word_sel;
    logic          wr_acc;

    assign tsel_w   = {2'b00, i_in_item.table_select};
    assign in_idx   = tsel_w[TW-1:0];
    assign tbl_ok   = {1'b0, tsel_w} < 7'(NUM_TABLES);
    assign word_sel = i_in_item.is_standard ? {1'b0, i_in_item.point_index}
                                            : 4'(NP) + {1'b0, i_in_item.point_index};
    assign wr_acc   = in_acc && (i_in_item.kind == pwlc_pkg::KIND_WRITE) && tbl_ok
                      && ({1'b0, i_in_item.point_index} < 4'(NP));

    logic [W-1:0]  rd [TWORDS];
    logic [TW-1:0] waddr;
    logic [W-1:0]  wdata;

    assign waddr = r_clr ? r_clr_idx : in_idx;
    assign wdata = r_clr ? '0 : i_in_item.value;

    for (genvar w = 0; w < TWORDS; w++) begin : g_bank
        pwlc_bank #(.DEPTH(NUM_TABLES)) u_bank (
            .i_clk   (i_clk),
            .i_we    (r_clr || (wr_acc && (word_sel == 4'(w)))),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (en),
            .i_raddr (in_idx),
            .o_rdata (rd[w])
        );
    end

    logic         r1_valid, r1_wr, r1_bad;
    logic [W-1:0] r1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_wr  <= i_in_item.kind == pwlc_pkg::KIND_WRITE;
            r1_bad <= !tbl_ok;
            r1_v   <= i_in_item.value;
        end
    end

    // stage 1: segment pick (banks 0..5 standard, 6..11 measured)
    logic         s1_byp;
    logic [W-1:0] s1_x0, s1_x1, s1_y0, s1_y1;

    always_comb begin
        s1_byp = 1'b0;
        for (int i = 0; i < NP; i++) begin
            if (rd[NP+i] == '0) begin
                s1_byp = 1'b1;
            end
        end
        s1_byp = s1_byp && !r1_bad;
        if (r1_v < rd[NP+1]) begin
            s1_x0 = rd[NP];   s1_x1 = rd[NP+1]; s1_y0 = rd[0]; s1_y1 = rd[1];
        end else if (r1_v >= rd[NP+4]) begin
            s1_x0 = rd[NP+4]; s1_x1 = rd[NP+5]; s1_y0 = rd[4]; s1_y1 = rd[5];
        end else if (r1_v < rd[NP+2]) begin
            s1_x0 = rd[NP+1]; s1_x1 = rd[NP+2]; s1_y0 = rd[1]; s1_y1 = rd[2];
        end else if (r1_v < rd[NP+3]) begin
            s1_x0 = rd[NP+2]; s1_x1 = rd[NP+3]; s1_y0 = rd[2]; s1_y1 = rd[3];
        end else begin
            // v < X[4] holds here, so a segment always exists
            s1_x0 = rd[NP+3]; s1_x1 = rd[NP+4]; s1_y0 = rd[3]; s1_y1 = rd[4];
        end
    end

    logic         r2_valid, r2_wr, r2_status, r2_byp;
    logic [W-1:0] r2_v, r2_x0, r2_x1, r2_y0, r2_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_wr     <= r1_wr;
            r2_status <= r1_bad;
            r2_byp    <= s1_byp;
            r2_v      <= r1_v;
            r2_x0     <= s1_x0;
            r2_x1     <= s1_x1;
            r2_y0     <= s1_y0;
            r2_y1     <= s1_y1;
        end
    end

    // stage 2: magnitudes and sign of the slope term
    logic [W-1:0] s2_dy, s2_dv, s2_den;
    logic         s2_neg;

    always_comb begin
        s2_dy  = (r2_y1 >= r2_y0) ? r2_y1 - r2_y0 : r2_y0 - r2_y1;
        s2_dv  = (r2_v >= r2_x0) ? r2_v - r2_x0 : r2_x0 - r2_v;
        s2_den = (r2_x1 >= r2_x0) ? r2_x1 - r2_x0 : r2_x0 - r2_x1;
        s2_neg = (r2_y1 < r2_y0) ^ (r2_v < r2_x0) ^ (r2_x1 < r2_x0);
    end

    logic         r3_valid, r3_wr, r3_status, r3_byp, r3_pass, r3_neg;
    logic [W-1:0] r3_v, r3_y0, r3_dy, r3_dv, r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_wr     <= r2_wr;
            r3_status <= r2_status;
            r3_byp    <= r2_byp;
            r3_pass   <= r2_status || r2_byp || (r2_x0 == r2_x1);
            r3_neg    <= s2_neg;
            r3_v      <= r2_v;
            r3_y0     <= r2_y0;
            r3_dy     <= s2_dy;
            r3_dv     <= s2_dv;
            r3_den    <= s2_den;
        end
    end

    // stage 3: product
    logic           r4_valid;
    logic [2*W-1:0] r4_mag;
    logic [W-1:0]   r4_den;
    pwlc_pkg::t_side r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mag         <= {{W{1'b0}}, r3_dy} * {{W{1'b0}}, r3_dv};
            r4_den         <= r3_den;
            r4_side.wr     <= r3_wr;
            r4_side.pass   <= r3_pass;
            r4_side.status <= r3_status;
            r4_side.byp    <= r3_byp;
            r4_side.neg    <= r3_neg;
            r4_side.ovf    <= 1'b0;
            r4_side.v      <= r3_v;
            r4_side.y0     <= r3_y0;
        end
    end

    // stage 4: quotient of 2^33 or more saturates either way
    pwlc_pkg::t_side s4_side;

    always_comb begin
        s4_side     = r4_side;
        s4_side.ovf = {1'b0, r4_mag[2*W-1:pwlc_pkg::DIV_STEPS]} >= r4_den;
    end

    logic                           d_valid;
    logic [pwlc_pkg::DIV_STEPS-1:0] d_quo;
    logic [W-1:0]                   d_rem, d_den;
    pwlc_pkg::t_side                d_side;

    pwlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_num   (r4_mag),
        .i_den   (r4_den),
        .i_side  (s4_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_den   (d_den),
        .o_side  (d_side)
    );

    // rounding: half up on the true value, so ties go away from zero only if positive
    logic [W:0] twice_r;
    logic       rnd;

    assign twice_r = {d_rem, 1'b0};
    assign rnd     = d_side.neg ? (twice_r > {1'b0, d_den}) : (twice_r >= {1'b0, d_den});

    logic                         r5_valid;
    logic [pwlc_pkg::DIV_STEPS:0] r5_q;
    pwlc_pkg::t_side              r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_q    <= {1'b0, d_quo} + (pwlc_pkg::DIV_STEPS + 1)'(rnd);
            r5_side <= d_side;
        end
    end

    // final select and saturation
    logic [pwlc_pkg::DIV_STEPS+1:0] sum;
    pwlc_pkg::t_out_item            n_out;

    assign sum = {3'b000, r5_side.y0} + {1'b0, r5_q};

    always_comb begin
        n_out = '0;
        if (r5_side.wr) begin
            n_out = '0;
        end else if (r5_side.pass) begin
            n_out.out_value = r5_side.v;
            n_out.status    = r5_side.status;
            n_out.bypassed  = r5_side.byp;
        end else if (r5_side.ovf) begin
            n_out.out_value = r5_side.neg ? '0 : '1;
        end else if (!r5_side.neg) begin
            n_out.out_value = (sum[pwlc_pkg::DIV_STEPS+1:W] != '0) ? '1 : sum[W-1:0];
        end else begin
            n_out.out_value = (r5_q > {2'b00, r5_side.y0}) ? '0
                                                            : r5_side.y0 - r5_q[W-1:0];
        end
    end

    pwlc_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `PWLC_ASSERT_NOW(a_clr_blocks_input, i_clk, i_rst_n, r_clr, !in_acc, "item taken while clearing")
    `PWLC_ASSERT_NEXT(a_clr_once, i_clk, i_rst_n, !r_clr, !r_clr, "clearing pass restarted")
    `PWLC_ASSERT_NOW(a_byp_status, i_clk, i_rst_n, o_out_valid && o_out_item.bypassed, !o_out_item.status, "bypass with error status")
    `PWLC_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !en, $stable(r1_valid) && $stable(r5_valid), "pipeline moved during stall")

endmodule
